### rtl/ipv6ow_pkg.sv
package ipv6ow_pkg;

	typedef enum logic [1:0] {
		PHASE_TYPE = 2'd0,
		PHASE_LEN  = 2'd1,
		PHASE_STOP = 2'd2
	} phase_t;

	localparam logic [1:0] VERDICT_ACCEPT  = 2'd0;
	localparam logic [1:0] VERDICT_DROP    = 2'd1;
	localparam logic [1:0] VERDICT_PROBLEM = 2'd2;

	localparam logic [7:0] ACT_MASK    = 8'hC0;
	localparam logic [7:0] ACT_PROBLEM = 8'h80;
	localparam logic [7:0] ACT_DROP    = 8'h40;

	localparam logic [11:0] WALK_START = 12'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first;
		logic       packet_end;
		logic       dst_multicast;
		logic       type_claimed;
	} in_beat_t;

	typedef struct packed {
		logic [11:0] byte_position;
		logic [11:0] total_length;
		logic [7:0]  saved_nh;
		logic [11:0] walk_position;
		phase_t      walk_phase;
		logic [11:0] option_start;
		logic        multicast_flag;
		logic        finished;
		logic        pending_problem;
	} walk_state_t;

	typedef struct packed {
		logic        valid;
		logic [1:0]  verdict;
		logic [7:0]  nh_value;
		logic [11:0] header_length;
		logic [11:0] problem_offset;
	} result_t;

endpackage

### rtl/ipv6_options_header_walker_unit.sv
// Walks an IPv6 Hop-by-Hop or Destination Options header one byte per beat and
// gives one verdict beat per header: accept, drop, or parameter problem with the
// offset of the offending option type byte. A byte is registered on entry and
// evaluated against the walk counters, and the verdict that it decides is
// registered once more in the output register before it is driven out. The unit
// takes a new byte in every cycle; only a stalled verdict beat that is not taken
// holds up the input. The verdict comes with the header's last byte, or earlier
// as a drop when tlast marks the end of the packet before the header is complete.
module ipv6_options_header_walker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // data_byte[7:0]
	input  logic        s_axis_tlast,
	input  logic [2:0]  s_axis_tuser,  // first, dst_multicast, type_claimed
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata, // nh_value[7:0], header_length[11:0],
	                                  // problem_offset[11:0]
	output logic [1:0]  m_axis_tuser  // verdict[1:0]
);
	import ipv6ow_pkg::*;

	logic        valid_s1;
	in_beat_t    beat_s1;
	walk_state_t state_q;
	walk_state_t state_next;
	result_t     res;
	logic        out_valid_q;
	logic [1:0]  verdict_q;
	logic [31:0] out_data_q;
	logic        out_free;
	logic        advance;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	ipv6ow_step u_step (
		.beat(beat_s1),
		.cur (state_q),
		.nxt (state_next),
		.res (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			beat_s1.data_byte     <= s_axis_tdata;
			beat_s1.first         <= s_axis_tuser[0];
			beat_s1.packet_end    <= s_axis_tlast;
			beat_s1.dst_multicast <= s_axis_tuser[1];
			beat_s1.type_claimed  <= s_axis_tuser[2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.byte_position     <= '0;
			state_q.total_length      <= '0;
			state_q.saved_nh          <= '0;
			state_q.walk_position     <= WALK_START;
			state_q.walk_phase        <= PHASE_TYPE;
			state_q.option_start      <= '0;
			state_q.multicast_flag    <= 1'b0;
			state_q.finished          <= 1'b1;
			state_q.pending_problem   <= 1'b0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			verdict_q  <= res.verdict;
			out_data_q <= {res.problem_offset, res.header_length, res.nh_value};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = verdict_q;

endmodule

### rtl/ipv6ow_step.sv
module ipv6ow_step (
	input  ipv6ow_pkg::in_beat_t    beat,
	input  ipv6ow_pkg::walk_state_t cur,
	output ipv6ow_pkg::walk_state_t nxt,
	output ipv6ow_pkg::result_t     res
);
	import ipv6ow_pkg::*;

	logic [11:0] pos;
	logic [7:0]  act;
	logic [8:0]  len_plus_one;
	logic        at_header_end;
	logic [1:0]  verdict;
	logic [11:0] offset;
	logic        emit;

	always_comb begin
		nxt          = cur;
		emit         = 1'b0;
		verdict      = VERDICT_ACCEPT;
		offset       = '0;
		pos          = cur.byte_position;
		act          = beat.data_byte & ACT_MASK;
		len_plus_one = {1'b0, beat.data_byte} + 9'd1;
		at_header_end = 1'b0;

		if (beat.first) begin
			nxt.saved_nh          = beat.data_byte;
			nxt.multicast_flag    = beat.dst_multicast;
			nxt.byte_position     = 12'd1;
			nxt.total_length      = '0;
			nxt.walk_position     = WALK_START;
			nxt.walk_phase        = PHASE_TYPE;
			nxt.option_start      = '0;
			nxt.pending_problem   = 1'b0;
			nxt.finished          = 1'b0;
			if (beat.packet_end) begin
				emit    = 1'b1;
				verdict = VERDICT_DROP;
			end
		end else if (!cur.finished) begin
			if (pos < 12'd2) begin
				nxt.total_length = {len_plus_one, 3'b000};
			end else if (cur.walk_phase == PHASE_TYPE) begin
				if (pos == cur.walk_position) begin
					if (beat.data_byte == 8'd0) begin
						nxt.walk_position = pos + 12'd1;
					end else if (act != 8'd0 && !beat.type_claimed) begin
						nxt.option_start = pos;
						nxt.walk_phase   = PHASE_STOP;
						nxt.pending_problem = !(act == ACT_DROP ||
							(act == ACT_MASK && cur.multicast_flag));
					end else begin
						nxt.option_start = pos;
						nxt.walk_phase   = PHASE_LEN;
					end
				end
			end else if (cur.walk_phase == PHASE_LEN) begin
				nxt.walk_position = pos + 12'd1 + {4'd0, beat.data_byte};
				nxt.walk_phase    = PHASE_TYPE;
			end

			nxt.byte_position = pos + 12'd1;

			// The compare is one bit wider so that a wrapped position never matches.
			at_header_end = (pos >= 12'd1) &&
				(({1'b0, pos} + 13'd1) == {1'b0, nxt.total_length});

			if (at_header_end) begin
				emit = 1'b1;
				if (nxt.walk_phase == PHASE_LEN) begin
					verdict = VERDICT_DROP;
				end else if (nxt.walk_phase == PHASE_STOP) begin
					verdict = nxt.pending_problem ? VERDICT_PROBLEM : VERDICT_DROP;
					offset  = nxt.option_start;
				end else begin
					verdict = VERDICT_ACCEPT;
				end
			end else if (beat.packet_end) begin
				emit    = 1'b1;
				verdict = VERDICT_DROP;
			end
		end

		if (emit) begin
			nxt.finished = 1'b1;
		end

		res.valid          = emit;
		res.verdict        = verdict;
		res.nh_value       = nxt.saved_nh;
		res.header_length  = nxt.total_length;
		res.problem_offset = (verdict == VERDICT_PROBLEM) ? offset : 12'd0;
	end

endmodule
